### rtl/assert_macros.svh
// Assertion macros for the checker file of the project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is applied.
`define RSA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);

// Concurrent assertion that also holds while the reset is applied.
`define RSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

### rtl/rsa_pkg.sv
// Package for the RSA modular exponentiation block: word width, reset values
// of the key registers and the register map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsa_pkg;

	// Default width of message, modulus, exponent and ciphertext.
	localparam int RSA_WORD_BITS = 16;

	// Key register reset values (modulus is 61 * 97).
	localparam int RSA_MOD_RESET = 5917;
	localparam int RSA_EXP_RESET = 7;

	// Register index on the configuration port.
	localparam logic [0:0] REG_MODULUS  = 1'b0;
	localparam logic [0:0] REG_EXPONENT = 1'b1;

endpackage
`default_nettype wire

### rtl/rsa_stream_if.sv
// Valid/ready stream interfaces for the message and ciphertext channels.
// Depends on rsa_pkg for the default word width.
`timescale 1ns / 1ps
`default_nettype none

// Message channel: one plain message word per handshake.
interface rsa_msg_if import rsa_pkg::*; #(
	parameter int WORD_BITS = RSA_WORD_BITS
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] message;

	modport source (output valid, output message, input ready);
	modport sink (input valid, input message, output ready);
endinterface

// Ciphertext channel: one encrypted word per handshake.
interface rsa_ct_if import rsa_pkg::*; #(
	parameter int WORD_BITS = RSA_WORD_BITS
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] ciphertext;

	modport source (output valid, output ciphertext, input ready);
	modport sink (input valid, input ciphertext, output ready);
endinterface

`default_nettype wire

### rtl/rsa_modexp_encrypt.sv
// RSA encryption: message ^ exponent mod modulus.
// Channels: msg (sink, one message word per handshake) and ct (source, one
// ciphertext word per handshake). Modulus and exponent are written over the
// APB port: modulus at register 0, exponent at register 1 (byte address 4*i,
// 8*i when WORD_BITS exceeds 32). Write them only while the block is idle.
// One word at a time: msg.ready is high only while no word is in work.
// A word is first reduced by the modulus (restoring remainder), then raised
// by left-to-right square-and-multiply: WORD_BITS squarings and one multiply
// per set exponent bit. Each modular product runs bit-serially: a doubling
// per multiplier bit, plus an add where that bit is set. All steps go through
// one shared modular adder, which sets the rate. A zero modulus gives zero.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; a finished result waits in the last step if ct stalls.
// Reset clears the sequencer and output valid and loads modulus 5917, exponent 7.
// Depends on rsa_pkg, rsa_stream_if and rsa_modadd.
`timescale 1ns / 1ps
`default_nettype none
module rsa_modexp_encrypt import rsa_pkg::*; #(
	parameter int WORD_BITS = RSA_WORD_BITS,
	parameter int DATA_W    = (WORD_BITS > 32) ? 64 : 32,
	parameter int ADDR_LSB  = (WORD_BITS > 32) ? 3 : 2,
	parameter int ADDR_W    = ADDR_LSB + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rsa_msg_if.sink                msg,
	rsa_ct_if.source               ct,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam int CNT_W = $clog2(WORD_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_MUL_DBL,
		S_MUL_ADD,
		S_FINISH
	} state_t;

	state_t               state_q;
	logic [WORD_BITS-1:0] mod_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] msg_sh_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] prod_q;
	logic [WORD_BITS-1:0] mulb_q;
	logic [WORD_BITS-1:0] exp_sh_q;
	logic [CNT_W-1:0]     ecnt_q;
	logic [CNT_W-1:0]     mcnt_q;
	logic                 phase_mul_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] ciphertext_q;

	logic [WORD_BITS-1:0] add_a;
	logic [WORD_BITS-1:0] add_b;
	logic                 add_cin;
	logic [WORD_BITS-1:0] sum_w;
	logic [WORD_BITS-1:0] acc_init;
	logic                 reg_wr;
	logic [0:0]           reg_idx;

	// Register access decode; the port never stalls.
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_LSB:ADDR_LSB];

	// Key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= WORD_BITS'(RSA_MOD_RESET);
			exp_q <= WORD_BITS'(RSA_EXP_RESET);
		end else if (reg_wr) begin
			case (reg_idx)
				REG_MODULUS:  mod_q <= pwdata[WORD_BITS-1:0];
				REG_EXPONENT: exp_q <= pwdata[WORD_BITS-1:0];
				default:      ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx)
			REG_MODULUS:  prdata = DATA_W'(mod_q);
			REG_EXPONENT: prdata = DATA_W'(exp_q);
			default:      prdata = '0;
		endcase
	end

	// Operand selection for the shared modular adder.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		case (state_q)
			S_REDUCE: begin
				add_a   = base_q;
				add_b   = base_q;
				add_cin = msg_sh_q[WORD_BITS-1];
			end
			S_MUL_DBL: begin
				add_a = prod_q;
				add_b = prod_q;
			end
			S_MUL_ADD: begin
				add_a = prod_q;
				add_b = phase_mul_q ? base_q : acc_q;
			end
			default: ;
		endcase
	end

	rsa_modadd #(
		.WORD_BITS(WORD_BITS)
	) u_modadd (
		.a  (add_a),
		.b  (add_b),
		.cin(add_cin),
		.m  (mod_q),
		.sum(sum_w)
	);

	// Starting value of the power: 1 mod modulus.
	assign acc_init = (mod_q == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			msg_sh_q     <= '0;
			base_q       <= '0;
			acc_q        <= '0;
			prod_q       <= '0;
			mulb_q       <= '0;
			exp_sh_q     <= '0;
			ecnt_q       <= '0;
			mcnt_q       <= '0;
			phase_mul_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			ciphertext_q <= '0;
		end else begin
			if (ct.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (msg.valid) begin
						if (mod_q == '0) begin
							acc_q   <= '0;
							state_q <= S_FINISH;
						end else begin
							msg_sh_q <= msg.message;
							base_q   <= '0;
							mcnt_q   <= CNT_W'(WORD_BITS - 1);
							state_q  <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					// Restoring remainder, one message bit per cycle.
					base_q   <= sum_w;
					msg_sh_q <= msg_sh_q << 1;
					mcnt_q   <= mcnt_q - 1'b1;
					if (mcnt_q == '0) begin
						acc_q       <= acc_init;
						mulb_q      <= acc_init;
						prod_q      <= '0;
						exp_sh_q    <= exp_q;
						ecnt_q      <= CNT_W'(WORD_BITS - 1);
						mcnt_q      <= CNT_W'(WORD_BITS - 1);
						phase_mul_q <= 1'b0;
						state_q     <= S_MUL_DBL;
					end
				end
				S_MUL_DBL, S_MUL_ADD: begin
					prod_q <= sum_w;
					if (state_q == S_MUL_DBL && mulb_q[WORD_BITS-1]) begin
						state_q <= S_MUL_ADD;
					end else begin
						mulb_q  <= mulb_q << 1;
						mcnt_q  <= mcnt_q - 1'b1;
						state_q <= S_MUL_DBL;
						if (mcnt_q == '0) begin
							// Product done: it becomes the new power.
							acc_q  <= sum_w;
							prod_q <= '0;
							mulb_q <= sum_w;
							mcnt_q <= CNT_W'(WORD_BITS - 1);
							if (!phase_mul_q && exp_sh_q[WORD_BITS-1]) begin
								phase_mul_q <= 1'b1;
							end else begin
								phase_mul_q <= 1'b0;
								exp_sh_q    <= exp_sh_q << 1;
								ecnt_q      <= ecnt_q - 1'b1;
								if (ecnt_q == '0) begin
									state_q <= S_FINISH;
								end
							end
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || ct.ready) begin
						out_valid_q  <= 1'b1;
						ciphertext_q <= acc_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign msg.ready     = (state_q == S_IDLE);
	assign ct.valid      = out_valid_q;
	assign ct.ciphertext = ciphertext_q;

endmodule
`default_nettype wire

### rtl/rsa_modadd.sv
// Shared modular adder: (a + b + cin) mod m for a sum below twice the modulus.
// Depends on rsa_pkg for the default word width.
`timescale 1ns / 1ps
`default_nettype none
module rsa_modadd import rsa_pkg::*; #(
	parameter int WORD_BITS = RSA_WORD_BITS
) (
	input  wire logic [WORD_BITS-1:0] a,
	input  wire logic [WORD_BITS-1:0] b,
	input  wire logic                 cin,
	input  wire logic [WORD_BITS-1:0] m,
	output logic      [WORD_BITS-1:0] sum
);

	logic [WORD_BITS:0] raw;
	logic [WORD_BITS:0] diff;

	// One wide add, then one compare and subtract of the modulus.
	always_comb begin
		raw  = {1'b0, a} + {1'b0, b} + {{WORD_BITS{1'b0}}, cin};
		diff = raw - {1'b0, m};
		if (raw >= {1'b0, m}) begin
			sum = diff[WORD_BITS-1:0];
		end else begin
			sum = raw[WORD_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

### rtl/rsa_chk.sv
// Port-level checker for the RSA modular exponentiation block, bound to the
// top level. Depends on rsa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rsa_chk import rsa_pkg::*; #(
	parameter int WORD_BITS = RSA_WORD_BITS
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 msg_valid,
	input wire logic                 msg_ready,
	input wire logic                 ct_valid,
	input wire logic                 ct_ready,
	input wire logic [WORD_BITS-1:0] ct_ciphertext
);

	// A waiting ciphertext word stays offered until it is taken.
	`RSA_ASSERT(a_ct_hold, clk, arst_n, ct_valid && !ct_ready |=> ct_valid, "ct word dropped")

	// A waiting ciphertext word keeps its value.
	`RSA_ASSERT(a_ct_stable, clk, arst_n, ct_valid && !ct_ready |=> $stable(ct_ciphertext), "ct word changed while stalled")

	// One word at a time: the block is busy right after it takes a word.
	`RSA_ASSERT(a_busy_after_accept, clk, arst_n, msg_valid && msg_ready |=> !msg_ready, "second word taken while busy")

	// A new result only appears out of a busy cycle.
	`RSA_ASSERT(a_result_from_work, clk, arst_n, $rose(ct_valid) |-> $past(!msg_ready), "result without work")

	// Nothing is offered while reset is applied.
	`RSA_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !ct_valid, "ct valid during reset")

endmodule

bind rsa_modexp_encrypt rsa_chk #(
	.WORD_BITS(WORD_BITS)
) u_rsa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_valid    (msg.valid),
	.msg_ready    (msg.ready),
	.ct_valid     (ct.valid),
	.ct_ready     (ct.ready),
	.ct_ciphertext(ct.ciphertext)
);
`default_nettype wire
